FILE: rtl/core/tzbd_pkg.sv
package tzbd_pkg;

    typedef struct packed {
        logic [3:0]  touch_points;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [31:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic        pressed;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [2:0]  button;
    } report_t;

    typedef struct packed {
        logic [1:0]  rotation;
        logic [12:0] native_width;
        logic [12:0] native_height;
        logic [15:0] min_gap_ms;
        logic        coords_prescaled;
    } cfg_t;

    typedef struct packed {
        logic        was_down;
        logic [31:0] last_fire_ms;
        logic [11:0] last_x;
        logic [11:0] last_y;
    } track_t;

    localparam logic [2:0] CFG_ROTATION   = 3'd0;
    localparam logic [2:0] CFG_NATIVE_W   = 3'd1;
    localparam logic [2:0] CFG_NATIVE_H   = 3'd2;
    localparam logic [2:0] CFG_DEBOUNCE   = 3'd3;
    localparam logic [2:0] CFG_PRESCALED  = 3'd4;

    localparam logic [2:0] BTN_NONE   = 3'd0;
    localparam logic [2:0] BTN_UP     = 3'd1;
    localparam logic [2:0] BTN_DOWN   = 3'd2;
    localparam logic [2:0] BTN_LEFT   = 3'd3;
    localparam logic [2:0] BTN_RIGHT  = 3'd4;
    localparam logic [2:0] BTN_CENTER = 3'd5;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [12:0] DIM_MAX = 13'd4096;

    // n * RECIP5 >> RECIP5_SHIFT equals n / 5 for every n below 81920
    localparam logic [15:0] RECIP5       = 16'd52429;
    localparam int          RECIP5_SHIFT = 18;

    localparam logic [12:0] RST_NATIVE_W = 13'd320;
    localparam logic [12:0] RST_NATIVE_H = 13'd480;
    localparam logic [15:0] RST_DEBOUNCE = 16'd50;

endpackage

FILE: rtl/core/tzbd_core.sv
module tzbd_core #(
    parameter int PANEL_W = 320,
    parameter int PANEL_H = 480
) (
    input  tzbd_pkg::poll_t   item,
    input  tzbd_pkg::cfg_t    cfg,
    input  tzbd_pkg::track_t  track,
    output tzbd_pkg::report_t report,
    output tzbd_pkg::track_t  track_next
);
    import tzbd_pkg::*;

    localparam logic [15:0] PW_M1 = 16'(PANEL_W - 1);
    localparam logic [15:0] PH_M1 = 16'(PANEL_H - 1);

    logic [12:0] nw;
    logic [12:0] nh;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [28:0] h5_prod;
    logic [30:0] h45_prod;
    logic [10:0] h_fifth;
    logic [12:0] h_four_fifths;
    logic [10:0] w_quarter;
    logic [14:0] w_triple;
    logic [12:0] w_three_quarters;
    logic [31:0] elapsed;
    logic        touched;
    logic        fire;
    logic [2:0]  zone;

    always_comb
    begin
        if (cfg.native_width == 13'd0)
            nw = 13'd1;
        else if (cfg.native_width > DIM_MAX)
            nw = DIM_MAX;
        else
            nw = cfg.native_width;
        if (cfg.native_height == 13'd0)
            nh = 13'd1;
        else if (cfg.native_height > DIM_MAX)
            nh = DIM_MAX;
        else
            nh = cfg.native_height;
    end

    assign w = cfg.rotation[0] ? nh : nw;
    assign h = cfg.rotation[0] ? nw : nh;

    // mirrored coordinates wrap at 16 bits; the clamp folds them to the edge
    assign fx = PW_M1 - {4'b0, item.raw_x};
    assign fy = PH_M1 - {4'b0, item.raw_y};

    always_comb
    begin
        if (cfg.coords_prescaled)
        begin
            sx = {4'b0, item.raw_x};
            sy = {4'b0, item.raw_y};
        end
        else
        begin
            unique case (cfg.rotation)
                ROT_0:
                begin
                    sx = {4'b0, item.raw_x};
                    sy = {4'b0, item.raw_y};
                end
                ROT_90:
                begin
                    sx = {4'b0, item.raw_y};
                    sy = fx;
                end
                ROT_180:
                begin
                    sx = fx;
                    sy = fy;
                end
                ROT_270:
                begin
                    sx = fy;
                    sy = {4'b0, item.raw_x};
                end
                default:
                begin
                    sx = {4'b0, item.raw_x};
                    sy = {4'b0, item.raw_y};
                end
            endcase
        end
    end

    logic [12:0] w_m1;
    logic [12:0] h_m1;
    assign w_m1 = w - 13'd1;
    assign h_m1 = h - 13'd1;
    assign cx = (sx >= {3'b0, w}) ? w_m1[11:0] : sx[11:0];
    assign cy = (sy >= {3'b0, h}) ? h_m1[11:0] : sy[11:0];

    assign h5_prod          = {16'b0, h} * {13'b0, RECIP5};
    assign h45_prod         = {16'b0, h, 2'b00} * {15'b0, RECIP5};
    assign h_fifth          = h5_prod[28:RECIP5_SHIFT];
    assign h_four_fifths    = h45_prod[30:RECIP5_SHIFT];
    assign w_quarter        = w[12:2];
    assign w_triple         = {2'b0, w} + {1'b0, w, 1'b0};
    assign w_three_quarters = w_triple[14:2];

    always_comb
    begin
        priority if ({1'b0, cy} < {1'b0, h_fifth, 1'b0} >> 1)
            zone = BTN_UP;
        else if ({1'b0, cy} > h_four_fifths)
            zone = BTN_DOWN;
        else if ({1'b0, cx} < {2'b0, w_quarter})
            zone = BTN_LEFT;
        else if ({1'b0, cx} > w_three_quarters)
            zone = BTN_RIGHT;
        else
            zone = BTN_CENTER;
    end

    assign touched = item.touch_points != 4'd0;
    assign elapsed = item.now_ms - track.last_fire_ms;
    assign fire    = touched && !track.was_down && (elapsed >= {16'b0, cfg.min_gap_ms});

    always_comb
    begin
        track_next = track;
        if (touched)
        begin
            track_next.was_down = 1'b1;
            track_next.last_x   = cx;
            track_next.last_y   = cy;
            if (fire)
                track_next.last_fire_ms = item.now_ms;
        end
        else
            track_next.was_down = 1'b0;
    end

    assign report.pressed = touched;
    assign report.pos_x   = track_next.last_x;
    assign report.pos_y   = track_next.last_y;
    assign report.button  = fire ? zone : BTN_NONE;

endmodule

FILE: rtl/core/touch_zone_button_decoder.sv
// Stages: the poll register, then the report register that holds each report.
// Throughput: one poll per cycle unless report_ready stalls; the zone logic sits
// between the poll and report registers, with press state updated as polls advance.
// Reset: rst_n is asynchronous, active low; it empties both stages, clears the
// press tracking state and loads the register defaults (0, 320, 480, 50, 0).
module touch_zone_button_decoder #(
    parameter int PANEL_W = 320,
    parameter int PANEL_H = 480
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              poll_valid,
    output logic              poll_ready,
    input  tzbd_pkg::poll_t   poll,
    output logic              report_valid,
    input  logic              report_ready,
    output tzbd_pkg::report_t report,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import tzbd_pkg::*;

    cfg_t    cfg_reg;
    track_t  track_reg;
    track_t  track_next;
    poll_t   stage_reg;
    logic    stage_valid_reg;
    report_t report_reg;
    report_t report_next;
    logic    report_valid_reg;
    logic    advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation         <= ROT_0;
            cfg_reg.native_width     <= RST_NATIVE_W;
            cfg_reg.native_height    <= RST_NATIVE_H;
            cfg_reg.min_gap_ms       <= RST_DEBOUNCE;
            cfg_reg.coords_prescaled <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROTATION:  cfg_reg.rotation         <= cfg_data[1:0];
                CFG_NATIVE_W:  cfg_reg.native_width     <= cfg_data[12:0];
                CFG_NATIVE_H:  cfg_reg.native_height    <= cfg_data[12:0];
                CFG_DEBOUNCE:  cfg_reg.min_gap_ms       <= cfg_data;
                CFG_PRESCALED: cfg_reg.coords_prescaled <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign advance    = stage_valid_reg && (!report_valid_reg || report_ready);
    assign poll_ready = !stage_valid_reg || advance;

    tzbd_core #(
        .PANEL_W (PANEL_W),
        .PANEL_H (PANEL_H)
    ) u_core (
        .item       (stage_reg),
        .cfg        (cfg_reg),
        .track      (track_reg),
        .report     (report_next),
        .track_next (track_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            report_valid_reg <= 1'b0;
            track_reg        <= '0;
        end
        else
        begin
            if (poll_valid && poll_ready)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
            begin
                report_valid_reg <= 1'b1;
                track_reg        <= track_next;
            end
            else if (report_ready)
                report_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && poll_ready)
            stage_reg <= poll;
        if (advance)
            report_reg <= report_next;
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

`ifndef SYNTHESIS
    a_button_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && report.button != BTN_NONE |-> report.pressed)
        else $error("button reported without a press");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_reg.touch_points == 4'd0 |=> !track_reg.was_down)
        else $error("release did not clear press tracking");

    a_fire_stamps_time: assert property (@(posedge clk) disable iff (!rst_n)
        advance && report_next.button != BTN_NONE
        |=> track_reg.last_fire_ms == $past(stage_reg.now_ms))
        else $error("fired press did not record its timestamp");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !poll_ready |-> stage_valid_reg && report_valid_reg && !report_ready)
        else $error("poll stalled with room in the pipeline");
`endif

endmodule

FILE: verif/touch_zone_button_decoder_test.sv
`timescale 1ns / 1ps

module touch_zone_button_decoder_test;
    import tzbd_pkg::*;

    localparam int PANEL_W = 320;
    localparam int PANEL_H = 480;
    localparam int BLOCKS = 12;
    localparam int ITEMS_PER_BLOCK = 128;
    localparam int HOLD_CYCLES = 48;
    // no register behind this index, writes must be dropped
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic        set_cfg;
        logic [1:0]  rot;
        logic [15:0] nw;
        logic [15:0] nh;
        logic [15:0] deb;
        logic        pre;
        poll_t       p;
        logic        known;
        report_t     want;
    } step_t;

    localparam int DIRECTED_ROWS = 26;
    localparam step_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd0}, 1'b1, '{1'b0, 12'd0, 12'd0, BTN_NONE}},
        // inside debounce window of the reset timestamp
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd1, 12'd160, 12'd240, 32'd49}, 1'b1, '{1'b1, 12'd160, 12'd240, BTN_NONE}},
        // release ignores raw coordinates
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd4095, 12'd4095, 32'd60}, 1'b1, '{1'b0, 12'd160, 12'd240, BTN_NONE}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd1, 12'd160, 12'd240, 32'd100}, 1'b1, '{1'b1, 12'd160, 12'd240, BTN_CENTER}},
        // held touch
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd2, 12'd10, 12'd10, 32'd200}, 1'b1, '{1'b1, 12'd10, 12'd10, BTN_NONE}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd210}, 1'b1, '{1'b0, 12'd10, 12'd10, BTN_NONE}},
        // clamp to screen edge
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd15, 12'd4095, 12'd4095, 32'd220}, 1'b1, '{1'b1, 12'd319, 12'd479, BTN_DOWN}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd230}, 1'b1, '{1'b0, 12'd319, 12'd479, BTN_NONE}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd1, 12'd160, 12'd50, 32'd400}, 1'b1, '{1'b1, 12'd160, 12'd50, BTN_UP}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd410}, 1'b1, '{1'b0, 12'd160, 12'd50, BTN_NONE}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd1, 12'd10, 12'd240, 32'd500}, 1'b1, '{1'b1, 12'd10, 12'd240, BTN_LEFT}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd510}, 1'b1, '{1'b0, 12'd10, 12'd240, BTN_NONE}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd1, 12'd300, 12'd240, 32'd600}, 1'b1, '{1'b1, 12'd300, 12'd240, BTN_RIGHT}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd610}, 1'b1, '{1'b0, 12'd300, 12'd240, BTN_NONE}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd1, 12'd160, 12'd240, 32'hFFFF_FFFF}, 1'b1,
          '{1'b1, 12'd160, 12'd240, BTN_CENTER}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd0}, 1'b1, '{1'b0, 12'd160, 12'd240, BTN_NONE}},
        // timestamp wrapped: 21 ms elapsed, too soon
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd1, 12'd160, 12'd240, 32'd20}, 1'b1, '{1'b1, 12'd160, 12'd240, BTN_NONE}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd30}, 1'b1, '{1'b0, 12'd160, 12'd240, BTN_NONE}},
        // wrapped, exactly the debounce interval
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd1, 12'd160, 12'd240, 32'd49}, 1'b1, '{1'b1, 12'd160, 12'd240, BTN_CENTER}},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd55}, 1'b1, '{1'b0, 12'd160, 12'd240, BTN_NONE}},
        '{1'b1, ROT_90, 16'd320, 16'd480, 16'd0, 1'b0,
          '{4'd1, 12'd0, 12'd4095, 32'd60}, 1'b0, '0},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd65}, 1'b0, '0},
        // flipped coordinates wrap at 16 bits and clamp
        '{1'b1, ROT_180, 16'd4096, 16'd1, 16'd65535, 1'b0,
          '{4'd1, 12'd400, 12'd500, 32'd70}, 1'b0, '0},
        '{1'b0, ROT_0, 16'd0, 16'd0, 16'd0, 1'b0,
          '{4'd0, 12'd0, 12'd0, 32'd75}, 1'b0, '0},
        // zero and oversized dimensions
        '{1'b1, ROT_270, 16'd0, 16'hFFFF, 16'd0, 1'b0,
          '{4'd1, 12'd4095, 12'd0, 32'd80}, 1'b0, '0},
        '{1'b1, ROT_270, 16'd100, 16'd100, 16'd0, 1'b1,
          '{4'd1, 12'd4095, 12'd4095, 32'd90}, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        poll_valid;
    logic        poll_ready;
    poll_t       poll;
    logic        report_valid;
    logic        report_ready;
    report_t     report;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    cfg_t    zone_cfg = '{ROT_0, RST_NATIVE_W, RST_NATIVE_H, RST_DEBOUNCE, 1'b0};
    track_t  press_state = '0;
    report_t pending_reports [$];
    int      mismatches = 0;
    int      sender_gap_pct = 0;
    int      receiver_gap_pct = 0;
    bit      ready_hold = 1'b0;

    touch_zone_button_decoder #(
        .PANEL_W (PANEL_W),
        .PANEL_H (PANEL_H)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    function automatic logic [31:0] fit_dim(input logic [12:0] v);
        if (v == 13'd0)
            return 32'd1;
        if (v > DIM_MAX)
            return 32'(DIM_MAX);
        return 32'(v);
    endfunction

    // expected report for one poll; advances the press tracking state
    function automatic report_t decode_poll(input poll_t p);
        logic [31:0] nw, nh, w, h, sx, sy, elapsed;
        logic [15:0] fx, fy;
        report_t     r;
        nw = fit_dim(zone_cfg.native_width);
        nh = fit_dim(zone_cfg.native_height);
        w = zone_cfg.rotation[0] ? nh : nw;
        h = zone_cfg.rotation[0] ? nw : nh;
        r = '0;
        r.button = BTN_NONE;
        if (p.touch_points != 4'd0)
        begin
            fx = 16'(PANEL_W - 1 - int'(p.raw_x));
            fy = 16'(PANEL_H - 1 - int'(p.raw_y));
            if (zone_cfg.coords_prescaled)
            begin
                sx = 32'(p.raw_x);
                sy = 32'(p.raw_y);
            end
            else
            begin
                case (zone_cfg.rotation)
                    ROT_0:
                    begin
                        sx = 32'(p.raw_x);
                        sy = 32'(p.raw_y);
                    end
                    ROT_90:
                    begin
                        sx = 32'(p.raw_y);
                        sy = 32'(fx);
                    end
                    ROT_180:
                    begin
                        sx = 32'(fx);
                        sy = 32'(fy);
                    end
                    default:
                    begin
                        sx = 32'(fy);
                        sy = 32'(p.raw_x);
                    end
                endcase
            end
            if (sx >= w)
                sx = w - 32'd1;
            if (sy >= h)
                sy = h - 32'd1;
            press_state.last_x = sx[11:0];
            press_state.last_y = sy[11:0];
            r.pressed = 1'b1;
            elapsed = p.now_ms - press_state.last_fire_ms;
            if (!press_state.was_down && elapsed >= 32'(zone_cfg.min_gap_ms))
            begin
                press_state.last_fire_ms = p.now_ms;
                if (sy < h / 5)
                    r.button = BTN_UP;
                else if (sy > (h * 4) / 5)
                    r.button = BTN_DOWN;
                else if (sx < w / 4)
                    r.button = BTN_LEFT;
                else if (sx > (w * 3) / 4)
                    r.button = BTN_RIGHT;
                else
                    r.button = BTN_CENTER;
            end
            press_state.was_down = 1'b1;
        end
        else
        begin
            press_state.was_down = 1'b0;
        end
        r.pos_x = press_state.last_x;
        r.pos_y = press_state.last_y;
        return r;
    endfunction

    function automatic logic [11:0] pick_coord();
        if ($urandom_range(3) == 0)
            return 12'($urandom_range(4095));
        return 12'($urandom_range(PANEL_H + 40));
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd4096;
            2: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(1, 600));
        endcase
    endfunction

    // mostly steps around the debounce interval, now and then a jump anywhere
    function automatic logic [31:0] ms_step();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'($urandom_range(3));
            default: return 32'($urandom_range(0, 2 * int'(zone_cfg.min_gap_ms) + 4));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_poll(input poll_t p, input logic known, input report_t want);
        report_t predicted;
        while ($urandom_range(99) < sender_gap_pct)
        begin
            poll_valid <= 1'b0;
            @(posedge clk);
        end
        poll <= p;
        poll_valid <= 1'b1;
        do
            @(posedge clk);
        while (!poll_ready);
        predicted = decode_poll(p);
        pending_reports.push_back(known ? want : predicted);
    endtask

    // stop offering polls and wait until every report is back
    task automatic settle();
        poll_valid <= 1'b0;
        wait (pending_reports.size() == 0);
    endtask

    task automatic program_regs(input logic [1:0] rot, input logic [15:0] nw,
                                input logic [15:0] nh, input logic [15:0] deb,
                                input logic pre);
        logic [2:0]  idx [6];
        logic [15:0] wdata [6];
        idx = '{CFG_ROTATION, CFG_NATIVE_W, CFG_NATIVE_H, CFG_DEBOUNCE, CFG_PRESCALED,
                CFG_UNUSED};
        wdata[0] = 16'($urandom());
        wdata[0][1:0] = rot;
        wdata[1] = nw;
        wdata[2] = nh;
        wdata[3] = deb;
        wdata[4] = 16'($urandom());
        wdata[4][0] = pre;
        wdata[5] = 16'($urandom());
        for (int i = 0; i < 6; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= wdata[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                CFG_ROTATION:  zone_cfg.rotation = wdata[i][1:0];
                CFG_NATIVE_W:  zone_cfg.native_width = wdata[i][12:0];
                CFG_NATIVE_H:  zone_cfg.native_height = wdata[i][12:0];
                CFG_DEBOUNCE:  zone_cfg.min_gap_ms = wdata[i];
                CFG_PRESCALED: zone_cfg.coords_prescaled = wdata[i][0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        report_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold)
            begin
                ready_hold = 1'b0;
                report_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                report_ready <= ($urandom_range(99) >= receiver_gap_pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_reports
        report_t want;
        if (rst_n && report_valid && report_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t ns: report with nothing expected, got %h", $time, report);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("pressed", 32'(want.pressed), 32'(report.pressed));
                check_field("pos_x", 32'(want.pos_x), 32'(report.pos_x));
                check_field("pos_y", 32'(want.pos_y), 32'(report.pos_y));
                check_field("button", 32'(want.button), 32'(report.button));
            end
        end
    end

    initial
    begin
        poll_t       item;
        int          sent;
        int          touches;
        int          lifts;
        logic [31:0] clock_ms;

        rst_n = 1'b0;
        poll_valid = 1'b0;
        poll = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROTATION;
        cfg_data = '0;
        clock_ms = '0;
        sender_gap_pct = 9;
        receiver_gap_pct = 72;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].set_cfg)
            begin
                settle();
                program_regs(DIRECTED[i].rot, DIRECTED[i].nw, DIRECTED[i].nh,
                             DIRECTED[i].deb, DIRECTED[i].pre);
            end
            send_poll(DIRECTED[i].p, DIRECTED[i].known, DIRECTED[i].want);
        end

        for (int b = 0; b < BLOCKS; b++)
        begin
            if (b < 4)
            begin
                sender_gap_pct = 9;
                receiver_gap_pct = 72;
            end
            else if (b < 8)
            begin
                sender_gap_pct = 72;
                receiver_gap_pct = 9;
            end
            else
            begin
                sender_gap_pct = 0;
                receiver_gap_pct = 0;
            end
            settle();
            case (b)
                0: program_regs(ROT_0, 16'd320, 16'd480, 16'd50, 1'b0);
                1: program_regs(ROT_90, 16'd1, 16'd4096, 16'd0, 1'b0);
                2: program_regs(ROT_180, 16'd4096, 16'd1, 16'd65535, 1'b0);
                3: program_regs(ROT_270, 16'd0, 16'hFFFF, 16'd1, 1'b1);
                default: program_regs(2'($urandom_range(3)), pick_dim(), pick_dim(),
                                      ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                               : 16'($urandom_range(200)),
                                      ($urandom_range(3) == 0));
            endcase
            sent = 0;
            while (sent < ITEMS_PER_BLOCK)
            begin
                // long receiver stall with the sender still pushing
                if ((b == 2 || b == 9) && sent >= 40 && sent < 46)
                    ready_hold = 1'b1;
                if (b == 5 && sent >= 64 && sent < 70)
                    settle();
                if ($urandom_range(7) == 0)
                begin
                    item.touch_points = 4'($urandom_range(15));
                    item.raw_x = 12'($urandom_range(4095));
                    item.raw_y = 12'($urandom_range(4095));
                    item.now_ms = $urandom();
                    send_poll(item, 1'b0, '0);
                    sent++;
                end
                else
                begin
                    // release, then a touch held for a few polls
                    lifts = $urandom_range(1, 2);
                    touches = $urandom_range(1, 4);
                    for (int k = 0; k < lifts + touches; k++)
                    begin
                        item.touch_points = (k < lifts) ? 4'd0 : 4'($urandom_range(1, 15));
                        item.raw_x = pick_coord();
                        item.raw_y = pick_coord();
                        clock_ms = clock_ms + ms_step();
                        item.now_ms = clock_ms;
                        send_poll(item, 1'b0, '0);
                        sent++;
                    end
                end
            end
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("touch_zone_button_decoder regression: pass");
        else
            $display("touch_zone_button_decoder regression: fail");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("touch_zone_button_decoder regression: fail");
        $finish;
    end

endmodule
